// File: rtl/uad_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uad_pkg
// Types and constants shared by the user activity detector modules.
// ---------------------------------------------------------------------------
package uad_pkg;

  localparam int CoordBits = 14;
  localparam int TimeBits  = 32;
  localparam int StatBits  = 32;
  localparam int CfgBits   = 20;
  localparam int CfgIdxBits = 2;

  // position registers hold -1 until the first pointer position is known
  localparam int PosBits   = CoordBits + 1;
  localparam int DeltaBits = CoordBits + 2;
  localparam int MagBits   = CoordBits + 1;
  localparam int SqBits    = 2 * CoordBits + 2;
  localparam int RootBits  = CoordBits + 1;
  localparam int RemBits   = CoordBits + 4;
  localparam int IterBits  = $clog2(RootBits + 1);

  localparam int MoveSense   = 3;
  localparam int MotionGapMs = 1000;

  localparam logic [CfgBits-1:0] NoiseReset    = CfgBits'(1000);
  localparam logic [CfgBits-1:0] ActivityReset = CfgBits'(2000);
  localparam logic [CfgBits-1:0] IdleReset     = CfgBits'(5000);

  localparam logic [CfgIdxBits-1:0] CfgNoise    = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] CfgActivity = CfgIdxBits'(1);
  localparam logic [CfgIdxBits-1:0] CfgIdle     = CfgIdxBits'(2);

  typedef enum logic [2:0] {
    CMD_MOVE    = 3'd0,
    CMD_BUTTON  = 3'd1,
    CMD_KEY     = 3'd2,
    CMD_QUERY   = 3'd3,
    CMD_SUSPEND = 3'd4,
    CMD_RESUME  = 3'd5,
    CMD_IDLE    = 3'd6,
    CMD_CLEAR   = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ACT_IDLE      = 2'd0,
    ACT_NOISE     = 2'd1,
    ACT_ACTIVE    = 2'd2,
    ACT_SUSPENDED = 2'd3
  } act_state_e;

  typedef struct packed {
    logic [2:0]           cmd;
    logic [TimeBits-1:0]  event_time;
    logic [CoordBits-1:0] pos_x;
    logic [CoordBits-1:0] pos_y;
    logic signed [7:0]    wheel_step;
    logic                 pressed;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          act_mode;
    logic [StatBits-1:0] move_total;
    logic [StatBits-1:0] click_travel;
    logic [StatBits-1:0] press_total;
    logic [StatBits-1:0] key_total;
    logic [StatBits-1:0] mouse_time_ms;
  } out_item_t;

endpackage

// File: rtl/uad_dist.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uad_dist
// Euclidean distance, floor(sqrt(dx*dx + dy*dy)): one shared multiplier for
// the two squares, then a digit-by-digit square root, one root bit a cycle.
// ---------------------------------------------------------------------------
module uad_dist (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [uad_pkg::DeltaBits-1:0] dx_i,
  input  logic signed [uad_pkg::DeltaBits-1:0] dy_i,
  output logic                                done_o,
  output logic [uad_pkg::RootBits-1:0]        root_o
);
  import uad_pkg::*;

  typedef enum logic [1:0] {
    D_IDLE,
    D_SQX,
    D_SQY,
    D_ROOT
  } dstate_e;

  dstate_e              state_q, state_d;
  logic [MagBits-1:0]   ax_q, ax_d, ay_q, ay_d;
  logic [SqBits-1:0]    op_q, op_d;
  logic [RemBits-1:0]   rem_q, rem_d;
  logic [RootBits-1:0]  root_q, root_d;
  logic [IterBits-1:0]  cnt_q, cnt_d;
  logic                 done_q, done_d;

  logic [DeltaBits-1:0] dx_abs, dy_abs;
  logic [MagBits-1:0]   mul_a;
  logic [SqBits-1:0]    prod;
  logic [RemBits-1:0]   rem_sh, trial;

  assign dx_abs = dx_i[DeltaBits-1] ? DeltaBits'(-dx_i) : DeltaBits'(dx_i);
  assign dy_abs = dy_i[DeltaBits-1] ? DeltaBits'(-dy_i) : DeltaBits'(dy_i);

  assign mul_a = (state_q == D_SQX) ? ax_q : ay_q;
  assign prod  = SqBits'(mul_a) * SqBits'(mul_a);

  // bring down the next two operand bits and try root*4+1
  assign rem_sh = {rem_q[RemBits-3:0], op_q[SqBits-1 -: 2]};
  assign trial  = RemBits'({root_q, 2'b01});

  always_comb begin
    state_d = state_q;
    ax_d    = ax_q;
    ay_d    = ay_q;
    op_d    = op_q;
    rem_d   = rem_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    case (state_q)
      D_IDLE: begin
        if (start_i) begin
          ax_d    = dx_abs[MagBits-1:0];
          ay_d    = dy_abs[MagBits-1:0];
          state_d = D_SQX;
        end
      end
      D_SQX: begin
        op_d    = prod;
        state_d = D_SQY;
      end
      D_SQY: begin
        op_d    = op_q + prod;
        rem_d   = '0;
        root_d  = '0;
        cnt_d   = '0;
        state_d = D_ROOT;
      end
      D_ROOT: begin
        op_d = {op_q[SqBits-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[RootBits-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[RootBits-2:0], 1'b0};
        end
        cnt_d = cnt_q + IterBits'(1);
        if (cnt_q == IterBits'(RootBits - 1)) begin
          done_d  = 1'b1;
          state_d = D_IDLE;
        end
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q   <= ax_d;
    ay_q   <= ay_d;
    op_q   <= op_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// File: rtl/user_activity_detector_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// user_activity_detector_top
// Flow: a pointer move that counts as motion, or a click after an earlier
// click, needs the distance unit and waits in S_WAIT for its result; every
// other transaction goes from S_PREP straight to S_DONE. A new transaction
// is taken only in S_IDLE, once the last result has been committed.
// Reset: asynchronous, active low; state, threshold and statistic registers
// return to their reset values; item, distance and output data are not reset.
// ---------------------------------------------------------------------------
module user_activity_detector_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  uad_pkg::in_item_t                in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output uad_pkg::out_item_t               out_item_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [uad_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [uad_pkg::CfgBits-1:0]      cfg_data_i
);
  import uad_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_WAIT,
    S_DONE
  } state_e;

  localparam logic signed [DeltaBits-1:0] SensPos = DeltaBits'(MoveSense);
  localparam logic signed [DeltaBits-1:0] SensNeg = DeltaBits'(-MoveSense);
  localparam logic [TimeBits-1:0]         GapMax  = TimeBits'(MotionGapMs);

  state_e               state_q, state_d;
  in_item_t             item_q, item_d;
  logic                 moved_q, moved_d;
  logic [RootBits-1:0]  dist_q, dist_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;

  logic [CfgBits-1:0]   noise_q, noise_d, activity_q, activity_d, idle_q, idle_d;
  act_state_e           mode_q, mode_d;
  logic [TimeBits-1:0]  burst_q, burst_d, last_act_q, last_act_d;
  logic [TimeBits-1:0]  motion_t_q, motion_t_d;
  logic                 motion_seen_q, motion_seen_d;
  logic signed [PosBits-1:0] last_px_q, last_px_d, last_py_q, last_py_d;
  logic signed [PosBits-1:0] click_px_q, click_px_d, click_py_q, click_py_d;
  logic [StatBits-1:0]  move_sum_q, move_sum_d, click_sum_q, click_sum_d;
  logic [StatBits-1:0]  press_cnt_q, press_cnt_d, key_cnt_q, key_cnt_d;
  logic [StatBits-1:0]  mtime_q, mtime_d;

  logic                 in_accept, commit, click_valid, need_dist, is_action;
  logic signed [DeltaBits-1:0] mv_dx, mv_dy, ck_dx, ck_dy, dist_dx, dist_dy;
  logic                 moved_now;
  logic                 dist_start, dist_done;
  logic [RootBits-1:0]  dist_root;
  logic [TimeBits-1:0]  now, gap_act, burst_age, gap_motion;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign commit = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // deltas from the last pointer position, which is -1 before any move
  assign mv_dx = {2'b00, item_q.pos_x} - {last_px_q[PosBits-1], last_px_q};
  assign mv_dy = {2'b00, item_q.pos_y} - {last_py_q[PosBits-1], last_py_q};
  assign ck_dx = {click_px_q[PosBits-1], click_px_q} - {last_px_q[PosBits-1], last_px_q};
  assign ck_dy = {click_py_q[PosBits-1], click_py_q} - {last_py_q[PosBits-1], last_py_q};
  assign moved_now = (mv_dx >= SensPos) || (mv_dx <= SensNeg) ||
                     (mv_dy >= SensPos) || (mv_dy <= SensNeg) ||
                     (item_q.wheel_step != 8'sd0);
  assign click_valid = (click_px_q != '1);

  assign need_dist = ((cmd_e'(item_q.cmd) == CMD_MOVE) && moved_now) ||
                     ((cmd_e'(item_q.cmd) == CMD_BUTTON) && click_valid);
  assign dist_dx = (cmd_e'(item_q.cmd) == CMD_MOVE) ? mv_dx : ck_dx;
  assign dist_dy = (cmd_e'(item_q.cmd) == CMD_MOVE) ? mv_dy : ck_dy;
  assign dist_start = (state_q == S_PREP) && need_dist;

  uad_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dist_start),
    .dx_i    (dist_dx),
    .dy_i    (dist_dy),
    .done_o  (dist_done),
    .root_o  (dist_root)
  );

  assign now        = item_q.event_time;
  assign gap_act    = now - last_act_q;
  assign burst_age  = now - burst_q;
  assign gap_motion = now - motion_t_q;
  assign is_action  = ((cmd_e'(item_q.cmd) == CMD_MOVE) && moved_q) ||
                      (cmd_e'(item_q.cmd) == CMD_BUTTON) ||
                      (cmd_e'(item_q.cmd) == CMD_KEY);

  always_comb begin
    state_d       = state_q;
    item_d        = item_q;
    moved_d       = moved_q;
    dist_d        = dist_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_d         = out_q;
    noise_d       = noise_q;
    activity_d    = activity_q;
    idle_d        = idle_q;
    mode_d        = mode_q;
    burst_d       = burst_q;
    last_act_d    = last_act_q;
    motion_t_d    = motion_t_q;
    motion_seen_d = motion_seen_q;
    last_px_d     = last_px_q;
    last_py_d     = last_py_q;
    click_px_d    = click_px_q;
    click_py_d    = click_py_q;
    move_sum_d    = move_sum_q;
    click_sum_d   = click_sum_q;
    press_cnt_d   = press_cnt_q;
    key_cnt_d     = key_cnt_q;
    mtime_d       = mtime_q;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          item_d  = in_item_i;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        moved_d = moved_now;
        dist_d  = '0;
        state_d = need_dist ? S_WAIT : S_DONE;
      end
      S_WAIT: begin
        if (dist_done) begin
          dist_d  = dist_root;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (commit) begin
      if (is_action) begin
        case (mode_q)
          ACT_IDLE: begin
            burst_d = now;
            mode_d  = (activity_q == '0) ? ACT_ACTIVE : ACT_NOISE;
          end
          ACT_NOISE: begin
            if (gap_act > TimeBits'(noise_q)) begin
              burst_d = now;
            end else if (burst_age >= TimeBits'(activity_q)) begin
              mode_d = ACT_ACTIVE;
            end
          end
          default: ;
        endcase
        last_act_d = now;
      end

      case (cmd_e'(item_q.cmd))
        CMD_MOVE: begin
          if (moved_q) begin
            move_sum_d = move_sum_q + StatBits'(dist_q);
            if (motion_seen_q && (gap_motion < GapMax)) begin
              mtime_d = mtime_q + StatBits'(gap_motion);
            end
            motion_t_d    = now;
            motion_seen_d = 1'b1;
          end
          last_px_d = $signed({1'b0, item_q.pos_x});
          last_py_d = $signed({1'b0, item_q.pos_y});
        end
        CMD_BUTTON: begin
          if (click_valid) begin
            click_sum_d = click_sum_q + StatBits'(dist_q);
          end
          click_px_d = last_px_q;
          click_py_d = last_py_q;
          if (item_q.pressed) begin
            press_cnt_d = press_cnt_q + StatBits'(1);
          end
        end
        CMD_KEY: begin
          key_cnt_d = key_cnt_q + StatBits'(1);
        end
        CMD_QUERY: begin
          if ((mode_q == ACT_ACTIVE) && (gap_act > TimeBits'(idle_q))) begin
            mode_d = ACT_IDLE;
          end
        end
        CMD_SUSPEND: mode_d = ACT_SUSPENDED;
        CMD_RESUME,
        CMD_IDLE:    mode_d = ACT_IDLE;
        CMD_CLEAR: begin
          move_sum_d  = '0;
          click_sum_d = '0;
          press_cnt_d = '0;
          key_cnt_d   = '0;
          mtime_d     = '0;
        end
        default: ;
      endcase

      out_valid_d         = 1'b1;
      out_d.act_mode      = mode_d;
      out_d.move_total    = move_sum_d;
      out_d.click_travel  = click_sum_d;
      out_d.press_total   = press_cnt_d;
      out_d.key_total     = key_cnt_d;
      out_d.mouse_time_ms = mtime_d;
    end

    // a write to the noise, activity or idle register also drops the detector back to idle
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgNoise: begin
          noise_d = cfg_data_i;
          mode_d  = ACT_IDLE;
        end
        CfgActivity: begin
          activity_d = cfg_data_i;
          mode_d     = ACT_IDLE;
        end
        CfgIdle: begin
          idle_d = cfg_data_i;
          mode_d = ACT_IDLE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      noise_q       <= NoiseReset;
      activity_q    <= ActivityReset;
      idle_q        <= IdleReset;
      mode_q        <= ACT_IDLE;
      burst_q       <= '0;
      last_act_q    <= '0;
      motion_t_q    <= '0;
      motion_seen_q <= 1'b0;
      last_px_q     <= '1;
      last_py_q     <= '1;
      click_px_q    <= '1;
      click_py_q    <= '1;
      move_sum_q    <= '0;
      click_sum_q   <= '0;
      press_cnt_q   <= '0;
      key_cnt_q     <= '0;
      mtime_q       <= '0;
    end else begin
      state_q       <= state_d;
      out_valid_q   <= out_valid_d;
      noise_q       <= noise_d;
      activity_q    <= activity_d;
      idle_q        <= idle_d;
      mode_q        <= mode_d;
      burst_q       <= burst_d;
      last_act_q    <= last_act_d;
      motion_t_q    <= motion_t_d;
      motion_seen_q <= motion_seen_d;
      last_px_q     <= last_px_d;
      last_py_q     <= last_py_d;
      click_px_q    <= click_px_d;
      click_py_q    <= click_py_d;
      move_sum_q    <= move_sum_d;
      click_sum_q   <= click_sum_d;
      press_cnt_q   <= press_cnt_d;
      key_cnt_q     <= key_cnt_d;
      mtime_q       <= mtime_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    moved_q <= moved_d;
    dist_q  <= dist_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: tb/uad_check_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uad_check_pkg
// Scoreboard for the user activity detector: tracks detector mode, pointer
// and click positions and the usage statistics for every accepted event,
// and compares each result transaction against the oldest predicted report.
// ---------------------------------------------------------------------------
package uad_check_pkg;

  import uad_pkg::*;

  class activity_scoreboard;

    logic [CfgBits-1:0]  noise_ms;
    logic [CfgBits-1:0]  activity_ms;
    logic [CfgBits-1:0]  idle_ms;
    act_state_e          mode;
    logic [TimeBits-1:0] burst_start;
    logic [TimeBits-1:0] last_action;
    logic [TimeBits-1:0] last_motion_time;
    int                  last_px;
    int                  last_py;
    int                  click_px;
    int                  click_py;
    bit                  motion_seen;
    logic [StatBits-1:0] movement_sum;
    logic [StatBits-1:0] click_travel_sum;
    logic [StatBits-1:0] press_count;
    logic [StatBits-1:0] key_count;
    logic [StatBits-1:0] motion_time_sum;
    out_item_t           expected_reports[$];
    int                  errors;

    function new();
      noise_ms         = NoiseReset;
      activity_ms      = ActivityReset;
      idle_ms          = IdleReset;
      mode             = ACT_IDLE;
      burst_start      = '0;
      last_action      = '0;
      last_motion_time = '0;
      // -1 means no position known yet
      last_px          = -1;
      last_py          = -1;
      click_px         = -1;
      click_py         = -1;
      motion_seen      = 1'b0;
      movement_sum     = '0;
      click_travel_sum = '0;
      press_count      = '0;
      key_count        = '0;
      motion_time_sum  = '0;
      errors           = 0;
    endfunction

    static function logic [RootBits-1:0] int_sqrt(longint unsigned sq);
      logic [RootBits-1:0] root;
      longint unsigned     trial;
      root = '0;
      for (int b = RootBits - 1; b >= 0; b--) begin
        trial = longint'(root) | (longint'(1) << b);
        if (trial * trial <= sq) root = RootBits'(trial);
      end
      return root;
    endfunction

    static function logic [StatBits-1:0] travel(int ax, int ay, int bx, int by);
      longint          dx;
      longint          dy;
      longint unsigned sq;
      dx = ax - bx;
      dy = ay - by;
      sq = dx * dx + dy * dy;
      return StatBits'(int_sqrt(sq));
    endfunction

    function void mark_action(logic [TimeBits-1:0] now);
      case (mode)
        ACT_IDLE: begin
          burst_start = now;
          if (activity_ms == '0) mode = ACT_ACTIVE;
          else mode = ACT_NOISE;
        end
        ACT_NOISE: begin
          if (TimeBits'(now - last_action) > noise_ms) burst_start = now;
          else if (TimeBits'(now - burst_start) >= activity_ms) mode = ACT_ACTIVE;
        end
        default: ;
      endcase
      last_action = now;
    endfunction

    function void write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgBits-1:0] data);
      case (idx)
        CfgNoise:    noise_ms = data;
        CfgActivity: activity_ms = data;
        CfgIdle:     idle_ms = data;
        default:     return;
      endcase
      mode = ACT_IDLE;
    endfunction

    function void note_event(in_item_t ev);
      int                  x;
      int                  y;
      int                  dx;
      int                  dy;
      bit                  moved;
      logic [TimeBits-1:0] gap;
      out_item_t           report;
      case (cmd_e'(ev.cmd))
        CMD_MOVE: begin
          x = int'(ev.pos_x);
          y = int'(ev.pos_y);
          dx = x - last_px;
          dy = y - last_py;
          moved = dx >= MoveSense || dx <= -MoveSense || dy >= MoveSense ||
                  dy <= -MoveSense || ev.wheel_step != 0;
          if (moved) begin
            movement_sum += travel(x, y, last_px, last_py);
            mark_action(ev.event_time);
            gap = ev.event_time - last_motion_time;
            if (motion_seen && gap < MotionGapMs) motion_time_sum += gap;
            last_motion_time = ev.event_time;
            motion_seen = 1'b1;
          end
          last_px = x;
          last_py = y;
        end
        CMD_BUTTON: begin
          if (click_px != -1) begin
            click_travel_sum += travel(click_px, click_py, last_px, last_py);
          end
          click_px = last_px;
          click_py = last_py;
          mark_action(ev.event_time);
          if (ev.pressed) press_count++;
        end
        CMD_KEY: begin
          mark_action(ev.event_time);
          key_count++;
        end
        CMD_QUERY: begin
          if (mode == ACT_ACTIVE && TimeBits'(ev.event_time - last_action) > idle_ms) begin
            mode = ACT_IDLE;
          end
        end
        CMD_SUSPEND: mode = ACT_SUSPENDED;
        CMD_RESUME, CMD_IDLE: mode = ACT_IDLE;
        default: begin
          movement_sum     = '0;
          click_travel_sum = '0;
          press_count      = '0;
          key_count        = '0;
          motion_time_sum  = '0;
        end
      endcase
      report.act_mode      = mode;
      report.move_total    = movement_sum;
      report.click_travel  = click_travel_sum;
      report.press_total   = press_count;
      report.key_total     = key_count;
      report.mouse_time_ms = motion_time_sum;
      expected_reports.push_back(report);
    endfunction

    function void match(string field, logic [StatBits-1:0] want, logic [StatBits-1:0] got);
      if (want !== got) begin
        $error("%s expected %0d got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      if (expected_reports.size() == 0) begin
        $error("result transaction with no event pending");
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      match("act_mode", StatBits'(want.act_mode), StatBits'(got.act_mode));
      match("move_total", want.move_total, got.move_total);
      match("click_travel", want.click_travel, got.click_travel);
      match("press_total", want.press_total, got.press_total);
      match("key_total", want.key_total, got.key_total);
      match("mouse_time_ms", want.mouse_time_ms, got.mouse_time_ms);
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

  endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Testbench for user_activity_detector_top: directed event sequences walk
// the detector through every mode and statistic, then random phases of
// pointer walks, clicks, keys and queries run under several threshold
// settings with random idling on both channels and a long output hold-off.
// ---------------------------------------------------------------------------
module tb_top;

  import uad_pkg::*;
  import uad_check_pkg::*;

  localparam int CycleLimit   = 600000;
  localparam int SettleCycles = CoordBits + 10;
  localparam int HoldCycles   = 400;
  localparam int PhaseItems   = 255;
  localparam int MaxCoord     = (1 << CoordBits) - 1;
  localparam logic [CfgIdxBits-1:0] CfgSpare = CfgIdxBits'(3);

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CfgIdxBits-1:0] cfg_index = '0;
  logic [CfgBits-1:0]    cfg_data  = '0;

  activity_scoreboard    sb;
  int                    hold_request = 0;
  bit                    steady       = 1'b0;
  logic [TimeBits-1:0]   now_ms       = '0;
  int                    cur_x        = 0;
  int                    cur_y        = 0;
  int                    time_scale   = 1;

  user_activity_detector_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  function automatic in_item_t mk_event(cmd_e c, logic [TimeBits-1:0] t, int x, int y,
                                        int w, bit p);
    in_item_t ev;
    ev.cmd        = c;
    ev.event_time = t;
    ev.pos_x      = CoordBits'(x);
    ev.pos_y      = CoordBits'(y);
    ev.wheel_step = 8'(w);
    ev.pressed    = p;
    return ev;
  endfunction

  function automatic int step_coord(int c);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 55) v = c + int'($urandom_range(0, 8)) - 4;
    else if (r < 85) v = c + int'($urandom_range(0, 128)) - 64;
    else if (r < 93) v = int'($urandom_range(0, MaxCoord));
    else if (r < 97) v = 0;
    else v = MaxCoord;
    if (v < 0) v = 0;
    if (v > MaxCoord) v = MaxCoord;
    return v;
  endfunction

  // mostly short gaps around the thresholds, now and then a big jump or a wrap
  function automatic logic [TimeBits-1:0] advance_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) now_ms += $urandom_range(0, 300) * time_scale;
    else if (r < 75) now_ms += $urandom_range(0, 1500) * time_scale;
    else if (r < 92) now_ms += $urandom_range(0, 8000) * time_scale;
    else if (r < 97) now_ms += $urandom_range(0, 2000000);
    else now_ms = $urandom;
    return now_ms;
  endfunction

  function automatic in_item_t walk_event();
    int                  r;
    cmd_e                c;
    logic [TimeBits-1:0] t;
    int                  x;
    int                  y;
    int                  w;
    r = $urandom_range(0, 99);
    if (r < 45) c = CMD_MOVE;
    else if (r < 60) c = CMD_BUTTON;
    else if (r < 75) c = CMD_KEY;
    else if (r < 88) c = CMD_QUERY;
    else c = cmd_e'($urandom_range(4, 7));
    if (c == CMD_MOVE) begin
      cur_x = step_coord(cur_x);
      cur_y = step_coord(cur_y);
      x = cur_x;
      y = cur_y;
    end else begin
      x = $urandom_range(0, MaxCoord);
      y = $urandom_range(0, MaxCoord);
    end
    // suspend, resume, force idle and clear ignore the timestamp
    if (c <= CMD_QUERY) t = advance_time();
    else t = $urandom;
    w = ($urandom_range(0, 6) == 0) ? int'($urandom_range(0, 255)) : 0;
    return mk_event(c, t, x, y, w, $urandom_range(0, 1));
  endfunction

  function automatic in_item_t noise_event();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic int draw_gap();
    return steady ? 0 : int'($urandom_range(0, 12));
  endfunction

  // valid stays high into the next call when no gap follows
  task automatic send_event(in_item_t ev, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_event(ev);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgBits-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [CfgBits-1:0] noise, logic [CfgBits-1:0] activity,
                           logic [CfgBits-1:0] idle);
    drain();
    write_reg(CfgNoise, noise);
    write_reg(CfgActivity, activity);
    write_reg(CfgIdle, idle);
  endtask

  task automatic run_phase(int items);
    for (int k = 0; k < items; k++) begin
      if (k % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      if (k == items / 3) begin
        // long output hold-off while events keep coming back to back
        hold_request = HoldCycles;
        steady = 1'b1;
      end
      if (k == 2 * items / 3) drain();
      send_event(($urandom_range(0, 9) == 0) ? noise_event() : walk_event(), draw_gap());
    end
  endtask

  // result side
  initial begin
    int wait_cycles;
    int seen;
    bit out_steady;
    seen = 0;
    out_steady = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (seen % 40 == 0) out_steady = ($urandom_range(0, 3) == 0);
      if (hold_request > 0) begin
        wait_cycles = hold_request;
        hold_request = 0;
      end else begin
        wait_cycles = out_steady ? 0 : int'($urandom_range(0, 12));
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_report(out_item);
      seen++;
    end
  end

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed sequence at reset thresholds
    send_event(mk_event(CMD_QUERY, 32'd0, 0, 0, 0, 0), draw_gap());
    // first move from no position: one pixel off, not motion
    send_event(mk_event(CMD_MOVE, 32'd10, 0, 0, 0, 0), draw_gap());
    send_event(mk_event(CMD_MOVE, 32'd20, MaxCoord, MaxCoord, 0, 0), draw_gap());
    // wheel alone counts as motion
    send_event(mk_event(CMD_MOVE, 32'd500, MaxCoord, MaxCoord, -128, 1), draw_gap());
    send_event(mk_event(CMD_MOVE, 32'd900, MaxCoord - 2, MaxCoord, 0, 0), draw_gap());
    // first click has no earlier click position
    send_event(mk_event(CMD_BUTTON, 32'd1500, 0, 0, 0, 1), draw_gap());
    send_event(mk_event(CMD_MOVE, 32'd1700, 0, MaxCoord, 127, 0), draw_gap());
    send_event(mk_event(CMD_BUTTON, 32'd2100, MaxCoord, 0, -1, 0), draw_gap());
    send_event(mk_event(CMD_KEY, 32'd2500, 0, 0, 0, 0), draw_gap());
    send_event(mk_event(CMD_QUERY, 32'd7000, 0, 0, 0, 0), draw_gap());
    send_event(mk_event(CMD_QUERY, 32'd7501, 0, 0, 0, 0), draw_gap());
    send_event(mk_event(CMD_KEY, 32'd8000, 0, 0, 0, 0), draw_gap());
    // gap just over noise time restarts the burst
    send_event(mk_event(CMD_KEY, 32'd9001, 0, 0, 0, 0), draw_gap());
    send_event(mk_event(CMD_MOVE, 32'd9500, 100, 200, 0, 0), draw_gap());
    send_event(mk_event(CMD_SUSPEND, 32'hFFFF_FFFF, MaxCoord, MaxCoord, -1, 1), draw_gap());
    send_event(mk_event(CMD_KEY, 32'd9600, 0, 0, 0, 0), draw_gap());
    send_event(mk_event(CMD_RESUME, 32'd0, 0, 0, 0, 0), draw_gap());
    // burst across the timestamp wrap
    send_event(mk_event(CMD_KEY, 32'hFFFF_FF00, 0, 0, 0, 0), draw_gap());
    send_event(mk_event(CMD_KEY, 32'h0000_02E0, 0, 0, 0, 0), draw_gap());
    send_event(mk_event(CMD_KEY, 32'h0000_06C0, 0, 0, 0, 0), draw_gap());
    send_event(mk_event(CMD_KEY, 32'h0000_0700, 0, 0, 0, 0), draw_gap());
    send_event(mk_event(CMD_IDLE, 32'h1234_5678, 0, 0, 0, 0), draw_gap());
    send_event(mk_event(CMD_CLEAR, 32'd0, 0, 0, 0, 0), draw_gap());
    send_event(mk_event(CMD_BUTTON, 32'h0000_0800, 0, 0, 0, 1), draw_gap());
    drain();
    // unused register index leaves the mode alone
    write_reg(CfgSpare, '1);
    send_event(mk_event(CMD_KEY, 32'h0000_0900, 0, 0, 0, 0), draw_gap());
    drain();
    // zero activity time goes straight to active
    write_reg(CfgActivity, '0);
    send_event(mk_event(CMD_KEY, 32'h0000_0A00, 0, 0, 0, 0), draw_gap());
    now_ms = 32'h0000_0A00;

    configure(NoiseReset, ActivityReset, IdleReset);
    run_phase(PhaseItems);
    configure('0, '0, '0);
    run_phase(PhaseItems);
    time_scale = 700;
    configure('1, '1, '1);
    run_phase(PhaseItems);
    time_scale = 1;
    configure(CfgBits'(40), CfgBits'(250), CfgBits'(600));
    run_phase(PhaseItems);
    time_scale = 4;
    configure(CfgBits'($urandom_range(0, 20000)), CfgBits'($urandom_range(0, 20000)),
              CfgBits'($urandom_range(0, 20000)));
    run_phase(PhaseItems);
    time_scale = 300;
    configure(CfgBits'($urandom), CfgBits'($urandom), CfgBits'($urandom));
    run_phase(PhaseItems);

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
